FILE: sv/tsrc_pkg.sv
// shared types and constants for the timed signal with ranging capture unit
// no dependencies

package tsrc_pkg;

	localparam int DIST_BITS = 9;
	localparam logic [DIST_BITS-1:0] DIST_MAX = 9'd511;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int PULSE_BITS = 10;
	localparam int SCALE_BITS = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_RED_TICKS = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_TICKS = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_YELLOW_TICKS = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_TICKS = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NEAR_LIMIT_CM = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CM_PER_TICK_Q16 = 3'd5;

	localparam int IN_DATA_BITS = 8;
	localparam int OUT_DATA_BITS = 16;

	// result of one ranging step
	typedef struct packed {
		logic                 trigger_drive;
		logic                 capture_pulse;
		logic                 distance_valid;
		logic [DIST_BITS-1:0] distance_cm;
	} rng_result_t;

endpackage

FILE: sv/timed_signal_with_ranging_capture_unit.sv
// top level: phase timer for the red/green/yellow signal, config registers,
// ranging sequencer and output buffer; depends on tsrc_pkg, tsrc_ranger, tsrc_out_buf

// Usage
// Each word on the s_axis channel is one timebase tick; tdata bit 0 carries the
// sampled echo level. Each accepted tick yields exactly one word on m_axis with
// the lamp drives, trigger drive, capture pulse and the latest distance.
// The result word enters the output register, or the skid entry if that is full.
// Throughput: one tick per cycle while the buffer has room (one 16x16 scale multiply
// per tick). Config registers are written through cfg_wr_en/cfg_index/cfg_data while
// idle; the user must keep to this, as the block itself does not enforce it. Reset
// puts the signal in red with zero elapsed ticks, the sequencer in its trigger step,
// the last distance at zero and the registers at their defaults. When the receiver
// stalls, a second word is held in a skid entry; after that s_axis_tready stays low
// until m_axis takes a word, and no tick state advances.

module timed_signal_with_ranging_capture_unit import tsrc_pkg::*; #(
	parameter int ECHO_COUNT_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,  // [0] echo_level
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// [0] red_on, [1] yellow_on, [2] green_on, [3] trigger_drive,
	// [4] capture_pulse, [13:5] distance_cm, [14] distance_valid
	output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
	input  logic                      cfg_wr_en,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	typedef enum logic [1:0] {
		PH_RED,
		PH_GREEN,
		PH_YELLOW
	} phase_t;

	logic [31:0]           red_ticks_q, green_ticks_q, yellow_ticks_q;
	logic [PULSE_BITS-1:0] pulse_ticks_q;
	logic [DIST_BITS-1:0]  near_limit_q;
	logic [SCALE_BITS-1:0] scale_q;

	phase_t      phase_q;
	logic [31:0] elapsed_q;
	logic [31:0] phase_len;
	logic        phase_end, accept, red, leave_red;
	rng_result_t rng;
	logic [OUT_DATA_BITS-1:0] word;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign red       = (phase_q != PH_GREEN) && (phase_q != PH_YELLOW);
	assign phase_end = ({1'b0, elapsed_q} + 33'd1) >= {1'b0, phase_len};
	assign leave_red = red && phase_end;

	always_comb begin
		case (phase_q)
			PH_GREEN:  phase_len = green_ticks_q;
			PH_YELLOW: phase_len = yellow_ticks_q;
			default:   phase_len = red_ticks_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_ticks_q    <= 32'd10000000;
			green_ticks_q  <= 32'd10000000;
			yellow_ticks_q <= 32'd3000000;
			pulse_ticks_q  <= 10'd10;
			near_limit_q   <= 9'd38;
			scale_q        <= 16'd1124;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RED_TICKS:       red_ticks_q <= cfg_data;
				REG_GREEN_TICKS:     green_ticks_q <= cfg_data;
				REG_YELLOW_TICKS:    yellow_ticks_q <= cfg_data;
				REG_PULSE_TICKS:     pulse_ticks_q <= cfg_data[PULSE_BITS-1:0];
				REG_NEAR_LIMIT_CM:   near_limit_q <= cfg_data[DIST_BITS-1:0];
				REG_CM_PER_TICK_Q16: scale_q <= cfg_data[SCALE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RED;
			elapsed_q <= '0;
		end else if (accept) begin
			if (phase_end) begin
				elapsed_q <= '0;
				case (phase_q)
					PH_GREEN:  phase_q <= PH_YELLOW;
					PH_YELLOW: phase_q <= PH_RED;
					default:   phase_q <= PH_GREEN;
				endcase
			end else begin
				elapsed_q <= elapsed_q + 32'd1;
			end
		end
	end

	tsrc_ranger #(
		.ECHO_COUNT_BITS(ECHO_COUNT_BITS)
	) u_ranger (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (accept),
		.red            (red),
		.leave_red      (leave_red),
		.echo_level     (s_axis_tdata[0]),
		.pulse_ticks    (pulse_ticks_q),
		.near_limit_cm  (near_limit_q),
		.cm_per_tick_q16(scale_q),
		.result         (rng)
	);

	assign word = {1'b0, rng.distance_valid, rng.distance_cm, rng.capture_pulse,
		rng.trigger_drive, (phase_q == PH_GREEN), (phase_q == PH_YELLOW), red};

	tsrc_out_buf #(
		.WIDTH(OUT_DATA_BITS)
	) u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (word),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata)
	);

endmodule

FILE: sv/tsrc_ranger.sv
// ultrasonic ranging sequencer: trigger pulse, echo wait, echo count, cm conversion
// depends on tsrc_pkg

module tsrc_ranger import tsrc_pkg::*; #(
	parameter int ECHO_COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  logic                  red,
	input  logic                  leave_red,
	input  logic                  echo_level,
	input  logic [PULSE_BITS-1:0] pulse_ticks,
	input  logic [DIST_BITS-1:0]  near_limit_cm,
	input  logic [SCALE_BITS-1:0] cm_per_tick_q16,
	output rng_result_t           result
);

	typedef enum logic [1:0] {
		ST_TRIGGER,
		ST_WAIT,
		ST_COUNT
	} rng_state_t;

	localparam logic [ECHO_COUNT_BITS-1:0] CMAX = '1;

	rng_state_t                 state_q, state_d;
	logic [ECHO_COUNT_BITS-1:0] count_q, count_d, count_inc;
	logic [DIST_BITS-1:0]       last_dist_q, last_dist_d;

	logic [ECHO_COUNT_BITS+SCALE_BITS-1:0] prod;
	logic [ECHO_COUNT_BITS-1:0]            cm_raw;
	logic [31:0]                           cm_wide;
	logic [DIST_BITS-1:0]                  cm_sat;

	assign count_inc = (count_q < CMAX) ? count_q + 1'b1 : count_q;

	// floor(count * scale / 65536), saturated
	assign prod    = (ECHO_COUNT_BITS+SCALE_BITS)'(count_q) * (ECHO_COUNT_BITS+SCALE_BITS)'(cm_per_tick_q16);
	assign cm_raw  = prod[ECHO_COUNT_BITS+SCALE_BITS-1:SCALE_BITS];
	assign cm_wide = 32'(cm_raw);
	assign cm_sat  = (cm_wide > 32'(DIST_MAX)) ? DIST_MAX : cm_wide[DIST_BITS-1:0];

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		last_dist_d = last_dist_q;
		result.trigger_drive = 1'b0;
		result.capture_pulse = 1'b0;
		result.distance_valid = 1'b0;
		if (red) begin
			case (state_q)
				ST_TRIGGER: begin
					result.trigger_drive = 1'b1;
					count_d = count_inc;
					if (32'(count_inc) >= 32'(pulse_ticks) || count_inc == CMAX) begin
						state_d = ST_WAIT;
						count_d = '0;
					end
				end
				ST_WAIT: begin
					if (echo_level) begin
						state_d = ST_COUNT;
						count_d = ECHO_COUNT_BITS'(1);
					end
				end
				ST_COUNT: begin
					if (echo_level) begin
						count_d = count_inc;
					end else begin
						last_dist_d = cm_sat;
						result.distance_valid = 1'b1;
						result.capture_pulse = (cm_sat < near_limit_cm);
						state_d = ST_TRIGGER;
						count_d = '0;
					end
				end
				default: begin
					state_d = ST_TRIGGER;
					count_d = '0;
				end
			endcase
		end
		// a reading in progress is dropped when red ends
		if (leave_red) begin
			state_d = ST_TRIGGER;
			count_d = '0;
		end
		result.distance_cm = last_dist_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TRIGGER;
			count_q <= '0;
			last_dist_q <= '0;
		end else if (step_en) begin
			state_q <= state_d;
			count_q <= count_d;
			last_dist_q <= last_dist_d;
		end
	end

endmodule

FILE: sv/tsrc_out_buf.sv
// two-entry output buffer: output register plus skid entry
// depends on tsrc_pkg for nothing but house style; generic over width

module tsrc_out_buf import tsrc_pkg::*; #(
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic             head_vld_q, skid_vld_q;
	logic [WIDTH-1:0] head_q, skid_q;
	logic             push, pop, head_free;

	assign in_ready  = !skid_vld_q;
	assign out_valid = head_vld_q;
	assign out_data  = head_q;
	assign push      = in_valid && in_ready;
	assign pop       = head_vld_q && out_ready;
	assign head_free = !head_vld_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (head_free) begin
			if (skid_vld_q) begin
				head_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				head_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (head_free) begin
			head_q <= skid_vld_q ? skid_q : in_data;
		end else if (push) begin
			skid_q <= in_data;
		end
	end

endmodule
